// ===== design/bhp_pkg.sv =====
// Shared types and constants for the bitstream header parser.
package bhp_pkg;

  // Input item and result item as seen on the top-level ports.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_length;
    logic [21:0] data_start;
    logic [31:0] id_code;
  } result_t;

  // Input kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Classified operation carried from the front to the parser.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } op_item_t;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_PREAMBLE = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_TAG  = 3'd3;
  localparam logic [2:0] ST_NO_PAYLOAD   = 3'd4;
  localparam logic [2:0] ST_EARLY_END    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_PREAMBLE = 2'd0;
  localparam logic [1:0] REG_MAX_RECORDS  = 2'd1;
  localparam logic [1:0] REG_ID_OFFSET    = 2'd2;

  localparam logic [15:0] MAX_PREAMBLE_RESET = 16'd4096;
  localparam logic [7:0]  MAX_RECORDS_RESET  = 8'd32;
  localparam logic [15:0] ID_OFFSET_RESET    = 16'd128;

  localparam logic [21:0] POS_MAX  = 22'h3FFFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Record tags.
  localparam logic [7:0] TAG_FIRST   = 8'h61;
  localparam logic [7:0] TAG_LAST    = 8'h64;
  localparam logic [7:0] TAG_PAYLOAD = 8'h65;

  localparam int ITEM_QUEUE_DEPTH = 4;
  localparam int ITEM_PTR_W       = $clog2(ITEM_QUEUE_DEPTH);
  localparam int RES_QUEUE_DEPTH  = 2;
  localparam int RES_PTR_W        = $clog2(RES_QUEUE_DEPTH);

endpackage

// ===== design/bhp_front.sv =====
// Input side: classifies incoming items and queues them for the parser.
module bhp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  bhp_pkg::item_t    item,
  output logic              deq_valid,
  output bhp_pkg::op_item_t deq_item,
  input  logic              deq_take
);
  import bhp_pkg::*;

  op_item_t              slots [ITEM_QUEUE_DEPTH];
  logic [ITEM_PTR_W-1:0] wr_ptr;
  logic [ITEM_PTR_W-1:0] rd_ptr;
  logic [ITEM_PTR_W:0]   count;
  op_item_t              classified;
  logic                  keep;
  logic                  enq;

  // Kind 3 carries no meaning; it is accepted and dropped here.
  always_comb begin
    classified.data = item.data_byte;
    classified.op   = OP_BYTE;
    keep            = 1'b1;
    unique case (item.kind)
      KIND_START: classified.op = OP_START;
      KIND_BYTE:  classified.op = OP_BYTE;
      KIND_END:   classified.op = OP_END;
      default:    keep = 1'b0;
    endcase
  end

  assign full      = (count == (ITEM_PTR_W+1)'(ITEM_QUEUE_DEPTH));
  assign enq       = push && !full && keep;
  assign deq_valid = (count != '0);
  assign deq_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (ITEM_PTR_W+1)'(enq) - (ITEM_PTR_W+1)'(deq_take);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (ITEM_PTR_W+1)'(ITEM_QUEUE_DEPTH))
    else $error("item queue count beyond depth");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    deq_take |-> count != '0)
    else $error("parser took an item from an empty queue");

endmodule

// ===== design/bhp_result_queue.sv =====
// Two-entry result queue between the parser and the result port.
module bhp_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              enq,
  input  bhp_pkg::result_t  enq_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output bhp_pkg::result_t  head
);
  import bhp_pkg::*;

  result_t              slots [RES_QUEUE_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W:0]   count;
  logic                 deq;

  assign full  = (count == (RES_PTR_W+1)'(RES_QUEUE_DEPTH));
  assign empty = (count == '0);
  assign deq   = pop && !empty;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (RES_PTR_W+1)'(enq) - (RES_PTR_W+1)'(deq);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq |-> !full)
    else $error("result written into a full queue");

endmodule

// ===== design/bhp_engine.sv =====
// Byte-wide header parsing state machine; emits at most one result per parse.
module bhp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       max_preamble_len,
  input  logic [7:0]        max_records,
  input  logic [15:0]       id_word_offset,
  input  logic              in_valid,
  input  bhp_pkg::op_item_t in_item,
  output logic              in_take,
  input  logic              res_full,
  output logic              res_push,
  output bhp_pkg::result_t  res_data
);
  import bhp_pkg::*;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_PRE_LEN  = 11'b000_0000_0010,
    PH_PRE_SKIP = 11'b000_0000_0100,
    PH_MARKER   = 11'b000_0000_1000,
    PH_TAG      = 11'b000_0001_0000,
    PH_REC_LEN  = 11'b000_0010_0000,
    PH_REC_SKIP = 11'b000_0100_0000,
    PH_PAY_LEN  = 11'b000_1000_0000,
    PH_ID_SKIP  = 11'b001_0000_0000,
    PH_ID_READ  = 11'b010_0000_0000,
    PH_DONE     = 11'b100_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] skip_count, skip_count_next;
  logic [31:0] field_accum, field_accum_next;
  logic [2:0]  field_bytes, field_bytes_next;
  logic [7:0]  record_count, record_count_next;
  logic [21:0] byte_position, byte_position_next;
  logic [31:0] length_reg, length_reg_next;
  logic [21:0] offset_reg, offset_reg_next;

  logic [31:0] acc_shift;
  logic [2:0]  fb_inc;
  logic        got2;
  logic        got4;
  logic [15:0] skip_dec;
  logic [21:0] pos_inc;
  logic        active;
  logic        id_in_range;
  logic [31:0] id_word;

  // The parser only advances while the result queue has room.
  assign in_take = in_valid && !res_full;

  assign acc_shift   = {field_accum[23:0], in_item.data};
  assign fb_inc      = field_bytes + 3'd1;
  assign got2        = (fb_inc >= 3'd2);
  assign got4        = (fb_inc >= 3'd4);
  assign skip_dec    = skip_count - 16'd1;
  assign pos_inc     = (byte_position < POS_MAX) ? byte_position + 22'd1 : byte_position;
  assign active      = (phase != PH_IDLE) && (phase != PH_DONE);
  assign id_in_range = {1'b0, acc_shift} > ({17'd0, id_word_offset} + 33'd4);
  assign id_word     = (acc_shift == ALL_ONES) ? 32'd0 : acc_shift;

  always_comb begin
    phase_next         = phase;
    skip_count_next    = skip_count;
    field_accum_next   = field_accum;
    field_bytes_next   = field_bytes;
    record_count_next  = record_count;
    byte_position_next = byte_position;
    length_reg_next    = length_reg;
    offset_reg_next    = offset_reg;
    res_push           = 1'b0;
    res_data           = '0;

    if (in_take) begin
      unique case (in_item.op)
        OP_START: begin
          phase_next         = PH_PRE_LEN;
          skip_count_next    = '0;
          field_accum_next   = '0;
          field_bytes_next   = '0;
          record_count_next  = '0;
          byte_position_next = '0;
          length_reg_next    = '0;
          offset_reg_next    = '0;
        end
        OP_END: begin
          if (active) begin
            res_push   = 1'b1;
            phase_next = PH_DONE;
            if (phase == PH_ID_SKIP || phase == PH_ID_READ) begin
              res_data.status      = ST_OK;
              res_data.data_length = length_reg;
              res_data.data_start  = offset_reg;
            end else begin
              res_data.status = ST_EARLY_END;
            end
          end
        end
        OP_BYTE: begin
          if (active) begin
            byte_position_next = pos_inc;
            unique case (phase)
              PH_PRE_LEN, PH_MARKER, PH_REC_LEN: begin
                if (got2) begin
                  field_accum_next = '0;
                  field_bytes_next = '0;
                  if (phase == PH_PRE_LEN) begin
                    if (acc_shift[15:0] == 16'd0 || acc_shift[15:0] > max_preamble_len) begin
                      res_push        = 1'b1;
                      res_data.status = ST_BAD_PREAMBLE;
                      phase_next      = PH_DONE;
                    end else begin
                      skip_count_next = acc_shift[15:0];
                      phase_next      = PH_PRE_SKIP;
                    end
                  end else if (phase == PH_MARKER) begin
                    if (acc_shift[15:0] != 16'd1) begin
                      res_push        = 1'b1;
                      res_data.status = ST_BAD_MARKER;
                      phase_next      = PH_DONE;
                    end else if (max_records == 8'd0) begin
                      res_push        = 1'b1;
                      res_data.status = ST_NO_PAYLOAD;
                      phase_next      = PH_DONE;
                    end else begin
                      phase_next = PH_TAG;
                    end
                  end else if (acc_shift[15:0] == 16'd0) begin
                    // An empty record ends with its length bytes.
                    if (record_count >= max_records) begin
                      res_push        = 1'b1;
                      res_data.status = ST_NO_PAYLOAD;
                      phase_next      = PH_DONE;
                    end else begin
                      phase_next = PH_TAG;
                    end
                  end else begin
                    skip_count_next = acc_shift[15:0];
                    phase_next      = PH_REC_SKIP;
                  end
                end else begin
                  field_accum_next = acc_shift;
                  field_bytes_next = fb_inc;
                end
              end
              PH_PRE_SKIP: begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0) begin
                  phase_next = PH_MARKER;
                end
              end
              PH_TAG: begin
                if (in_item.data >= TAG_FIRST && in_item.data <= TAG_LAST) begin
                  record_count_next = record_count + 8'd1;
                  phase_next        = PH_REC_LEN;
                end else if (in_item.data == TAG_PAYLOAD) begin
                  phase_next = PH_PAY_LEN;
                end else begin
                  res_push        = 1'b1;
                  res_data.status = ST_UNKNOWN_TAG;
                  phase_next      = PH_DONE;
                end
              end
              PH_REC_SKIP: begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0) begin
                  if (record_count >= max_records) begin
                    res_push        = 1'b1;
                    res_data.status = ST_NO_PAYLOAD;
                    phase_next      = PH_DONE;
                  end else begin
                    phase_next = PH_TAG;
                  end
                end
              end
              PH_PAY_LEN: begin
                if (got4) begin
                  field_accum_next = '0;
                  field_bytes_next = '0;
                  length_reg_next  = acc_shift;
                  offset_reg_next  = pos_inc;
                  if (id_in_range) begin
                    skip_count_next = id_word_offset;
                    phase_next      = (id_word_offset != 16'd0) ? PH_ID_SKIP : PH_ID_READ;
                  end else begin
                    res_push             = 1'b1;
                    res_data.status      = ST_OK;
                    res_data.data_length = acc_shift;
                    res_data.data_start  = pos_inc;
                    phase_next           = PH_DONE;
                  end
                end else begin
                  field_accum_next = acc_shift;
                  field_bytes_next = fb_inc;
                end
              end
              PH_ID_SKIP: begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0) begin
                  phase_next = PH_ID_READ;
                end
              end
              PH_ID_READ: begin
                if (got4) begin
                  field_accum_next     = '0;
                  field_bytes_next     = '0;
                  res_push             = 1'b1;
                  res_data.status      = ST_OK;
                  res_data.data_length = length_reg;
                  res_data.data_start  = offset_reg;
                  res_data.id_code     = id_word;
                  phase_next           = PH_DONE;
                end else begin
                  field_accum_next = acc_shift;
                  field_bytes_next = fb_inc;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      skip_count    <= '0;
      field_accum   <= '0;
      field_bytes   <= '0;
      record_count  <= '0;
      byte_position <= '0;
      length_reg    <= '0;
      offset_reg    <= '0;
    end else begin
      phase         <= phase_next;
      skip_count    <= skip_count_next;
      field_accum   <= field_accum_next;
      field_bytes   <= field_bytes_next;
      record_count  <= record_count_next;
      byte_position <= byte_position_next;
      length_reg    <= length_reg_next;
      offset_reg    <= offset_reg_next;
    end
  end

  a_no_result_when_inactive: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_DONE) |-> !res_push)
    else $error("result produced outside a parse");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.status != ST_OK) |->
      (res_data.data_length == '0 && res_data.data_start == '0 &&
       res_data.id_code == '0))
    else $error("error result carries nonzero fields");

  a_result_ends_parse: assert property (@(posedge clk) disable iff (rst)
    res_push |=> phase == PH_DONE)
    else $error("parse did not finish after its result");

endmodule

// ===== design/bitstream_header_parser.sv =====
// Top level of the bitstream header parser: configuration registers and the
// front, parser and result queue.
//
// The block takes one transaction per clock on the input queue interface, one
// file byte at a time, and sustains one byte per cycle as long as results are
// drained. Items first land in a four-entry queue; the byte-wide parsing state
// machine retires one item per cycle from it while the result queue has room
// and writes at most one result per parse into a two-entry result queue,
// where each result is registered before it appears on the result ports. The
// parser stalls only while the result queue is full. Configuration registers
// are written through cfg_write, cfg_index and cfg_data; indexes beyond the
// three registers are ignored.
module bitstream_header_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  bhp_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output bhp_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import bhp_pkg::*;

  logic [15:0] max_preamble_len;
  logic [7:0]  max_records;
  logic [15:0] id_word_offset;

  logic        deq_valid;
  op_item_t    deq_item;
  logic        deq_take;
  logic        res_full;
  logic        res_push;
  result_t     res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_preamble_len <= MAX_PREAMBLE_RESET;
      max_records      <= MAX_RECORDS_RESET;
      id_word_offset   <= ID_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_PREAMBLE: max_preamble_len <= cfg_data;
        REG_MAX_RECORDS:  max_records      <= cfg_data[7:0];
        REG_ID_OFFSET:    id_word_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  bhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .deq_valid (deq_valid),
    .deq_item  (deq_item),
    .deq_take  (deq_take)
  );

  bhp_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .max_preamble_len (max_preamble_len),
    .max_records      (max_records),
    .id_word_offset   (id_word_offset),
    .in_valid         (deq_valid),
    .in_item          (deq_item),
    .in_take          (deq_take),
    .res_full         (res_full),
    .res_push         (res_push),
    .res_data         (res_data)
  );

  bhp_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (res_push),
    .enq_data (res_data),
    .full     (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (result)
  );

endmodule
